>>> rtl/assert_macros.svh
// Assertion macros used by quaternion_vector_rotation_unit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/qvr_pkg.sv
// Package with the constants of the quaternion vector rotation unit.
`default_nettype none
package qvr_pkg;
  localparam int unsigned AXES = 3;
  localparam int unsigned AX_X = 0;
  localparam int unsigned AX_Y = 1;
  localparam int unsigned AX_Z = 2;
endpackage
`default_nettype wire

>>> rtl/quaternion_vector_rotation_unit.sv
// Pipelined rotation of a vector by a quaternion with a pipelined divider.
// A request passes stages 1 to 4, divider stages 0 to VEC_BITS and the output register to the done strobe.
// Throughput: one request per cycle; busy is always low, and the divider
// retires one quotient bit per pipeline stage for all three axes.
// Reset clears only the valid bits; data in flight at reset is discarded.
`default_nettype none
`include "assert_macros.svh"
module quaternion_vector_rotation_unit #(
  parameter int QUAT_BITS = 16,
  parameter int VEC_BITS = 24
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [QUAT_BITS-1:0] quat_w,
  input  wire logic signed [QUAT_BITS-1:0] quat_x,
  input  wire logic signed [QUAT_BITS-1:0] quat_y,
  input  wire logic signed [QUAT_BITS-1:0] quat_z,
  input  wire logic signed [VEC_BITS-1:0]  vec_x,
  input  wire logic signed [VEC_BITS-1:0]  vec_y,
  input  wire logic signed [VEC_BITS-1:0]  vec_z,
  output logic                             done,
  output logic signed [VEC_BITS-1:0]       rot_x,
  output logic signed [VEC_BITS-1:0]       rot_y,
  output logic signed [VEC_BITS-1:0]       rot_z,
  output logic                             zero_quat,
  output logic                             saturated
);
  localparam int QB = QUAT_BITS;
  localparam int VB = VEC_BITS;
  localparam int PW = QB + VB;
  localparam int TW = PW + 2;
  localparam int MW = TW + QB;
  localparam int RW = MW + 2;
  localparam int NUMW = RW + 1;
  localparam int NRM = 2 * QB + 1;
  localparam int HIW = NUMW - VB;
  localparam int NA = qvr_pkg::AXES;

  assign busy = 1'b0;

  // Stage 1: products for the first Hamilton product and the squared norm.
  logic signed [PW-1:0] xvx, yvy, zvz, wvx, yvz, zvy, wvy, xvz, zvx, wvz, xvy, yvx;
  logic signed [2*QB-1:0] ww, xx, yy, zz;
  logic signed [QB-1:0] s1_w, s1_x, s1_y, s1_z;
  logic s1_vld;

  always_ff @(posedge clk) begin
    xvx <= quat_x * vec_x;  yvy <= quat_y * vec_y;  zvz <= quat_z * vec_z;
    wvx <= quat_w * vec_x;  yvz <= quat_y * vec_z;  zvy <= quat_z * vec_y;
    wvy <= quat_w * vec_y;  xvz <= quat_x * vec_z;  zvx <= quat_z * vec_x;
    wvz <= quat_w * vec_z;  xvy <= quat_x * vec_y;  yvx <= quat_y * vec_x;
    ww <= quat_w * quat_w;  xx <= quat_x * quat_x;
    yy <= quat_y * quat_y;  zz <= quat_z * quat_z;
    s1_w <= quat_w;  s1_x <= quat_x;  s1_y <= quat_y;  s1_z <= quat_z;
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start;
    end
  end

  // Stage 2: sums of the first product and the norm.
  logic signed [TW-1:0] tw, tx, ty, tz;
  logic [NRM-1:0] s2_norm;
  logic signed [QB-1:0] s2_w, s2_x, s2_y, s2_z;
  logic s2_vld;

  always_ff @(posedge clk) begin
    tw <= -(TW'(xvx) + TW'(yvy) + TW'(zvz));
    tx <= TW'(wvx) + TW'(yvz) - TW'(zvy);
    ty <= TW'(wvy) - TW'(xvz) + TW'(zvx);
    tz <= TW'(wvz) + TW'(xvy) - TW'(yvx);
    s2_norm <= NRM'(unsigned'(ww)) + NRM'(unsigned'(xx))
             + NRM'(unsigned'(yy)) + NRM'(unsigned'(zz));
    s2_w <= s1_w;  s2_x <= s1_x;  s2_y <= s1_y;  s2_z <= s1_z;
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  // Stage 3: products with the conjugate quaternion.
  logic signed [MW-1:0] twx, txw, tyz, tzy, twy, txz, tyw, tzx, twz, txy, tyx, tzw;
  logic [NRM-1:0] s3_norm;
  logic s3_vld;

  always_ff @(posedge clk) begin
    twx <= tw * s2_x;  txw <= tx * s2_w;  tyz <= ty * s2_z;  tzy <= tz * s2_y;
    twy <= tw * s2_y;  txz <= tx * s2_z;  tyw <= ty * s2_w;  tzx <= tz * s2_x;
    twz <= tw * s2_z;  txy <= tx * s2_y;  tyx <= ty * s2_x;  tzw <= tz * s2_w;
    s3_norm <= s2_norm;
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
  end

  // Stage 4: numerators, sign and rounding offset.
  logic signed [RW-1:0] r_sum [NA];
  logic [RW-1:0] r_mag [NA];
  logic [NUMW-1:0] s4_num [NA];
  logic s4_neg [NA];
  logic [NRM-1:0] s4_norm;
  logic s4_vld;

  always_comb begin
    r_sum[qvr_pkg::AX_X] = -RW'(twx) + RW'(txw) - RW'(tyz) + RW'(tzy);
    r_sum[qvr_pkg::AX_Y] = -RW'(twy) + RW'(txz) + RW'(tyw) - RW'(tzx);
    r_sum[qvr_pkg::AX_Z] = -RW'(twz) - RW'(txy) + RW'(tyx) + RW'(tzw);
    for (int c = 0; c < NA; c++) begin
      r_mag[c] = r_sum[c][RW-1] ? RW'(-r_sum[c]) : RW'(r_sum[c]);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < NA; c++) begin
      s4_num[c] <= {1'b0, r_mag[c]} + NUMW'(s3_norm >> 1);
      s4_neg[c] <= r_sum[c][RW-1];
    end
    s4_norm <= s3_norm;
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
  end

  // Divider: stage 0 checks for overflow, then one quotient bit per stage.
  logic [NRM-1:0] d_rem [VB+1][NA];
  logic [VB-1:0] d_lo [VB+1][NA];
  logic [VB-1:0] d_quo [VB+1][NA];
  logic d_ovf [VB+1][NA];
  logic d_neg [VB+1][NA];
  logic [NRM-1:0] d_norm [VB+1];
  logic d_vld [VB+1];

  always_ff @(posedge clk) begin
    for (int c = 0; c < NA; c++) begin
      d_ovf[0][c] <= s4_num[c][NUMW-1:VB] >= HIW'(s4_norm);
      d_rem[0][c] <= s4_num[c][NRM-1+VB:VB];
      d_lo[0][c] <= s4_num[c][VB-1:0];
      d_quo[0][c] <= '0;
      d_neg[0][c] <= s4_neg[c];
    end
    d_norm[0] <= s4_norm;
    if (rst) begin
      d_vld[0] <= 1'b0;
    end else begin
      d_vld[0] <= s4_vld;
    end
  end

  for (genvar k = 1; k <= VB; k++) begin : g_div
    logic [NRM:0] trial [NA];
    logic take [NA];

    always_comb begin
      for (int c = 0; c < NA; c++) begin
        trial[c] = {d_rem[k-1][c], d_lo[k-1][c][VB-1]};
        take[c] = trial[c] >= {1'b0, d_norm[k-1]};
      end
    end

    always_ff @(posedge clk) begin
      for (int c = 0; c < NA; c++) begin
        d_rem[k][c] <= take[c] ? NRM'(trial[c] - {1'b0, d_norm[k-1]}) : NRM'(trial[c]);
        d_lo[k][c] <= {d_lo[k-1][c][VB-2:0], 1'b0};
        d_quo[k][c] <= {d_quo[k-1][c][VB-2:0], take[c]};
        d_ovf[k][c] <= d_ovf[k-1][c];
        d_neg[k][c] <= d_neg[k-1][c];
      end
      d_norm[k] <= d_norm[k-1];
      if (rst) begin
        d_vld[k] <= 1'b0;
      end else begin
        d_vld[k] <= d_vld[k-1];
      end
    end
  end

  // Output stage: saturation, sign and the zero quaternion case.
  logic [VB-1:0] lim [NA];
  logic [VB-1:0] omag [NA];
  logic [VB-1:0] oval [NA];
  logic clip [NA];
  logic is_zero;

  always_comb begin
    is_zero = d_norm[VB] == '0;
    for (int c = 0; c < NA; c++) begin
      lim[c] = d_neg[VB][c] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
      clip[c] = !is_zero && (d_ovf[VB][c] || d_quo[VB][c] > lim[c]);
      omag[c] = clip[c] ? lim[c] : d_quo[VB][c];
      oval[c] = is_zero ? '0 : (d_neg[VB][c] ? VB'(-omag[c]) : omag[c]);
    end
  end

  always_ff @(posedge clk) begin
    rot_x <= oval[qvr_pkg::AX_X];
    rot_y <= oval[qvr_pkg::AX_Y];
    rot_z <= oval[qvr_pkg::AX_Z];
    zero_quat <= is_zero;
    saturated <= clip[qvr_pkg::AX_X] | clip[qvr_pkg::AX_Y] | clip[qvr_pkg::AX_Z];
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_vld[VB];
    end
  end

  `ASSERT_NEXT(a_result_follows, clk, rst, d_vld[VB], done)
  `ASSERT_IMPL(a_zero_clean, clk, rst, done && zero_quat,
    rot_x == '0 && rot_y == '0 && rot_z == '0 && !saturated)
  `ASSERT_NEXT(a_no_spurious_done, clk, rst, !d_vld[VB], !done)

endmodule
`default_nettype wire
